// ----- src/lrt_pkg.sv -----
package lrt_pkg;

  // Term values are residues below TERM_MOD
  localparam int unsigned VAL_W = 17;
  localparam logic [VAL_W-1:0] TERM_MOD = 17'd100007;

  // Multiply-reduce widths: one product, a sum of two products, and the
  // partial remainder that stays below 3*TERM_MOD
  localparam int unsigned PROD_W = 2 * VAL_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned RED_W  = 19;

  // Barrett quotient estimate: q = ((s >> BAR_SHIFT_A) * BAR_MU) >> BAR_SHIFT_B
  localparam int unsigned BAR_SHIFT_A = 16;
  localparam int unsigned BAR_SHIFT_B = 20;
  localparam int unsigned BAR_MU_W    = 20;
  localparam logic [BAR_MU_W-1:0] BAR_MU =
      BAR_MU_W'((64'd1 << (BAR_SHIFT_A + BAR_SHIFT_B)) / 64'(TERM_MOD));

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B = 1'b1;

  // Product select: bit 2 picks the left matrix (0 = acc, 1 = base),
  // bits 1:0 the row and column of the entry
  localparam int unsigned SEL_W = 3;
  localparam logic [SEL_W-1:0] SEL_ACC_FIRST  = 3'd0;
  localparam logic [SEL_W-1:0] SEL_BASE_FIRST = 3'd4;
  localparam logic [SEL_W-1:0] SEL_LAST       = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ISSUE,
    ST_DRAIN,
    ST_COMMIT,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic             load;
    logic             issue;
    logic [SEL_W-1:0] sel;
    logic             commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic expo_zero;
    logic expo_lsb;
    logic pipe_busy;
  } dp_stat_t;

  typedef struct packed {
    logic [VAL_W-1:0] e00;
    logic [VAL_W-1:0] e01;
    logic [VAL_W-1:0] e10;
    logic [VAL_W-1:0] e11;
  } mat_t;

endpackage

// ----- src/lrt_mulred.sv -----
module lrt_mulred import lrt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [SEL_W-1:0] in_tag_i,
  input  logic [VAL_W-1:0] x0_i,
  input  logic [VAL_W-1:0] y0_i,
  input  logic [VAL_W-1:0] x1_i,
  input  logic [VAL_W-1:0] y1_i,
  output logic             out_valid_o,
  output logic [SEL_W-1:0] out_tag_o,
  output logic [VAL_W-1:0] out_res_o,
  output logic             busy_o
);

  localparam int unsigned NSTAGE = 5;
  localparam int unsigned QHI_W  = SUM_W - BAR_SHIFT_A;
  localparam int unsigned EST_W  = QHI_W + BAR_MU_W;
  localparam logic [RED_W-1:0] MOD_R  = RED_W'(TERM_MOD);
  localparam logic [RED_W-1:0] MOD2_R = RED_W'({TERM_MOD, 1'b0});

  logic [NSTAGE-1:0] vld_q;
  logic [SEL_W-1:0]  tag_q [NSTAGE];
  logic [PROD_W-1:0] p0_q, p1_q;
  logic [SUM_W-1:0]  s_q;
  logic [EST_W-1:0]  est_q;
  logic [RED_W-1:0]  slo3_q, slo4_q, qm_q, qm_d, r_d;
  logic [VAL_W-1:0]  res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTAGE-2:0], in_valid_i};
    end
  end

  // qm only needs its low bits: r = s - q*M is known to be below 3*M
  always_comb begin
    qm_d = RED_W'(est_q[EST_W-1:BAR_SHIFT_B]) * MOD_R;
    r_d  = slo4_q - qm_q;
    if (r_d >= MOD2_R) begin
      res_d = VAL_W'(r_d - MOD2_R);
    end else if (r_d >= MOD_R) begin
      res_d = VAL_W'(r_d - MOD_R);
    end else begin
      res_d = VAL_W'(r_d);
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q     <= PROD_W'(x0_i) * PROD_W'(y0_i);
    p1_q     <= PROD_W'(x1_i) * PROD_W'(y1_i);
    s_q      <= SUM_W'(p0_q) + SUM_W'(p1_q);
    est_q    <= EST_W'(s_q[SUM_W-1:BAR_SHIFT_A]) * EST_W'(BAR_MU);
    slo3_q   <= s_q[RED_W-1:0];
    qm_q     <= qm_d;
    slo4_q   <= slo3_q;
    res_q    <= res_d;
    tag_q[0] <= in_tag_i;
    for (int i = 1; i < NSTAGE; i++) begin
      tag_q[i] <= tag_q[i-1];
    end
  end

  assign out_valid_o = vld_q[NSTAGE-1];
  assign out_tag_o   = tag_q[NSTAGE-1];
  assign out_res_o   = res_q;
  assign busy_o      = |vld_q;

endmodule

// ----- src/lrt_datapath.sv -----
module lrt_datapath import lrt_pkg::*; #(
  parameter int unsigned INDEX_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [VAL_W-1:0]      cfg_wdata_i,
  input  logic [INDEX_BITS-1:0] term_index_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_stat_t              stat_o,
  output logic [VAL_W-1:0]      term_value_o
);

  localparam mat_t IDENT = '{e00: VAL_W'(1), e01: '0, e10: '0, e11: VAL_W'(1)};

  logic [VAL_W-1:0]      coef_a_q, coef_a_d, coef_b_q, coef_b_d, cfg_red;
  logic [INDEX_BITS-1:0] expo_q;
  logic                  zero_q;
  mat_t                  acc_q, base_q, lhs, nxt_acc, nxt_base;
  logic [VAL_W-1:0]      nxt_q [2**SEL_W];
  logic [VAL_W-1:0]      x0, y0, x1, y1;
  logic                  mr_valid, mr_busy;
  logic [SEL_W-1:0]      mr_tag;
  logic [VAL_W-1:0]      mr_res;

  // Write data is below 2*M, so one conditional subtract reduces it
  always_comb begin
    cfg_red  = (cfg_wdata_i >= TERM_MOD) ? cfg_wdata_i - TERM_MOD : cfg_wdata_i;
    coef_a_d = coef_a_q;
    coef_b_d = coef_b_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COEF_A: coef_a_d = cfg_red;
        CFG_COEF_B: coef_b_d = cfg_red;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q <= VAL_W'(1);
      coef_b_q <= VAL_W'(1);
      expo_q   <= '0;
      zero_q   <= 1'b0;
    end else begin
      coef_a_q <= coef_a_d;
      coef_b_q <= coef_b_d;
      if (cmd_i.load) begin
        zero_q <= (term_index_i == '0);
        expo_q <= (term_index_i == '0) ? '0 : term_index_i - INDEX_BITS'(1);
      end else if (cmd_i.commit) begin
        expo_q <= expo_q >> 1;
      end
    end
  end

  // Operands of one entry: row of lhs times column of base
  always_comb begin
    lhs = cmd_i.sel[2] ? base_q : acc_q;
    x0  = cmd_i.sel[1] ? lhs.e10 : lhs.e00;
    x1  = cmd_i.sel[1] ? lhs.e11 : lhs.e01;
    y0  = cmd_i.sel[0] ? base_q.e01 : base_q.e00;
    y1  = cmd_i.sel[0] ? base_q.e11 : base_q.e10;
  end

  lrt_mulred u_mulred (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.issue),
    .in_tag_i    (cmd_i.sel),
    .x0_i        (x0),
    .y0_i        (y0),
    .x1_i        (x1),
    .y1_i        (y1),
    .out_valid_o (mr_valid),
    .out_tag_o   (mr_tag),
    .out_res_o   (mr_res),
    .busy_o      (mr_busy)
  );

  assign nxt_acc  = '{e00: nxt_q[0], e01: nxt_q[1], e10: nxt_q[2], e11: nxt_q[3]};
  assign nxt_base = '{e00: nxt_q[4], e01: nxt_q[5], e10: nxt_q[6], e11: nxt_q[7]};

  // Products land in a shadow set; acc and base change only at load and commit
  always_ff @(posedge clk_i) begin
    if (mr_valid) begin
      nxt_q[mr_tag] <= mr_res;
    end
    if (cmd_i.load) begin
      acc_q  <= IDENT;
      base_q <= '{e00: coef_a_q, e01: coef_b_q, e10: VAL_W'(1), e11: '0};
    end else if (cmd_i.commit) begin
      base_q <= nxt_base;
      if (expo_q[0]) begin
        acc_q <= nxt_acc;
      end
    end
  end

  assign stat_o.expo_zero = (expo_q == '0);
  assign stat_o.expo_lsb  = expo_q[0];
  assign stat_o.pipe_busy = mr_busy;
  assign term_value_o     = zero_q ? '0 : acc_q.e00;

  a_commit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !mr_busy)
    else $error("commit while products still in flight");

  a_acc_only_on_set_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.issue && !cmd_i.sel[2]) |-> expo_q[0])
    else $error("acc product issued for a clear exponent bit");

endmodule

// ----- src/lrt_ctrl.sv -----
module lrt_ctrl import lrt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o,
  output logic      busy_o,
  output logic      done_o
);

  ctrl_state_e      state_q, state_d;
  logic [SEL_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= SEL_ACC_FIRST;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_CHECK;
      ST_CHECK:  state_d = stat_i.expo_zero ? ST_FINISH : ST_ISSUE;
      ST_ISSUE:  if (cnt_q == SEL_LAST) state_d = ST_DRAIN;
      ST_DRAIN:  if (!stat_i.pipe_busy) state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_CHECK;
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o   = '0;
    cmd_o.sel = cnt_q;
    cnt_d   = cnt_q;
    busy_o  = (state_q != ST_IDLE);
    done_o  = 1'b0;
    case (state_q)
      ST_IDLE:   cmd_o.load = start_i;
      // skip the acc products when the exponent bit is clear
      ST_CHECK:  cnt_d = stat_i.expo_lsb ? SEL_ACC_FIRST : SEL_BASE_FIRST;
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        cnt_d       = cnt_q + SEL_W'(1);
      end
      ST_DRAIN:  ;
      ST_COMMIT: cmd_o.commit = 1'b1;
      ST_FINISH: done_o = 1'b1;
      default:   ;
    endcase
  end

endmodule

// ----- src/linear_recurrence_term_mod.sv -----
// Returns term k of f(k) = A*f(k-1) + B*f(k-2) mod 100007, f(0) = 0, f(1) = 1.
// Raise start with term_index_i while busy is low; the index is taken at
// that edge and busy stays high until the result is shown. The result is
// on term_value_o while done_o is high for exactly one cycle; there is no
// way to hold it, so the receiver must take it then. One index is worked at
// a time. busy drops in the cycle after the result, and the next index can
// be taken in that cycle. Each round is one square-and-multiply step of the
// 2x2 matrix [[A,B],[1,0]]; its entries go one per cycle through a single
// five-stage multiply/Barrett-reduce pipe, which then drains before the
// round commits. A and B (cfg index 0 and 1) are reduced mod 100007 on
// write, reset to 1, and should be written only while busy is low. Index
// bits above INDEX_BITS do not exist on the port.
module linear_recurrence_term_mod import lrt_pkg::*; #(
  parameter int unsigned INDEX_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic [INDEX_BITS-1:0] term_index_i,
  // result strobe
  output logic                  done_o,
  output logic [VAL_W-1:0]      term_value_o,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [VAL_W-1:0]      cfg_wdata_i
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer: load, per-round issue/drain/commit, result strobe
  lrt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // Coefficients, exponent, matrices and the multiply-reduce pipe
  lrt_datapath #(
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .term_index_i (term_index_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .term_value_o (term_value_o)
  );

  a_result_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (term_value_o < TERM_MOD))
    else $error("result not reduced");

  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("still busy after result transfer");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted index did not start work");

endmodule
